[hdl/rct_pkg.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rct_pkg: shared types and constants of the ranked contributor table
// Entry layout, input item layout, result layout and item kind codes.
// -----------------------------------------------------------------------------
package rct_pkg;

   localparam int SPECIES_W = 32;
   localparam int COUNT_W   = 32;
   localparam int AMOUNT_W  = 16;

   localparam logic [SPECIES_W-1:0] INVALID_SPECIES = '1;

   localparam logic KIND_ADD  = 1'b0;
   localparam logic KIND_ELIG = 1'b1;

   typedef struct packed {
      logic [SPECIES_W-1:0] species;
      logic [COUNT_W-1:0]   count;
      logic                 eligible;
   } entry_type;

   typedef struct packed {
      logic                  kind;
      logic [SPECIES_W-1:0]  species;
      logic [AMOUNT_W-1:0]   amount;
      logic                  eligible;
      logic                  last;
   } item_type;

   typedef struct packed {
      logic [SPECIES_W-1:0] main_species;
      logic                 main_valid;
      logic                 table_full;
   } result_type;

endpackage

[hdl/rct_if.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rct_if: request and response channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// -----------------------------------------------------------------------------
interface rct_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [31:0] species;
   logic [15:0] amount;
   logic        eligible;
   logic        last;

   modport source (output valid, output kind, output species, output amount,
                   output eligible, output last, input ready);
   modport sink   (input valid, input kind, input species, input amount,
                   input eligible, input last, output ready);
endinterface

interface rct_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] main_species;
   logic        main_valid;
   logic        table_full;

   modport source (output valid, output main_species, output main_valid,
                   output table_full, input ready);
   modport sink   (input valid, input main_species, input main_valid,
                   input table_full, output ready);
endinterface

[hdl/rct_mem.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rct_mem: entry storage
// One write port and one registered read port over the table entries.
// -----------------------------------------------------------------------------
module rct_mem #(
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  rct_pkg::entry_type wr_data,
   input  logic               rd_en,
   input  logic [ADDR_W-1:0]  rd_addr,
   output rct_pkg::entry_type rd_data
);
   import rct_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/rct_alu.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rct_alu: shared compare and saturating add unit
// Equality and less-than on one operand pair, and a saturating count add.
// -----------------------------------------------------------------------------
module rct_alu (
   input  logic [31:0] op_a,
   input  logic [31:0] op_b,
   input  logic [15:0] addend,
   output logic        eq,
   output logic        lt,
   output logic [31:0] sum_sat
);
   import rct_pkg::*;

   logic [COUNT_W:0] sum;

   assign eq      = (op_a == op_b);
   assign lt      = (op_a < op_b);
   assign sum     = {1'b0, op_a} + {{(COUNT_W + 1 - AMOUNT_W){1'b0}}, addend};
   assign sum_sat = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];

endmodule

[hdl/rct_ctrl.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rct_ctrl: table sequencer
// Searches, updates, insertion-sorts and scans the table one entry at a time.
// -----------------------------------------------------------------------------
module rct_ctrl #(
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH),
   localparam int USED_W = $clog2(DEPTH + 1)
) (
   input  logic                clock,
   input  logic                reset,
   rct_req_if.sink             req_bus,
   output logic                mem_wr_en,
   output logic [ADDR_W-1:0]   mem_wr_addr,
   output rct_pkg::entry_type  mem_wr_data,
   output logic                mem_rd_en,
   output logic [ADDR_W-1:0]   mem_rd_addr,
   input  rct_pkg::entry_type  mem_rd_data,
   output rct_pkg::result_type res_data,
   output logic                res_valid,
   input  logic                out_free
);
   import rct_pkg::*;

   typedef enum logic [11:0] {
      ST_IDLE     = 12'b0000_0000_0001,
      ST_FIND_RD  = 12'b0000_0000_0010,
      ST_FIND_CMP = 12'b0000_0000_0100,
      ST_APPLY    = 12'b0000_0000_1000,
      ST_SORT_RDI = 12'b0000_0001_0000,
      ST_SORT_LDI = 12'b0000_0010_0000,
      ST_SORT_RDJ = 12'b0000_0100_0000,
      ST_SORT_CMP = 12'b0000_1000_0000,
      ST_SORT_PUT = 12'b0001_0000_0000,
      ST_SCAN_RD  = 12'b0010_0000_0000,
      ST_SCAN_CMP = 12'b0100_0000_0000,
      ST_REPORT   = 12'b1000_0000_0000
   } state_type;

   state_type            state_ff, state_in;
   item_type             item_ff, item_in;
   entry_type            hold_ff, hold_in;
   logic [USED_W-1:0]    idx_ff, idx_in;
   logic [USED_W-1:0]    pos_ff, pos_in;
   logic [USED_W-1:0]    used_ff, used_in;
   logic                 full_seen_ff, full_seen_in;
   logic                 hit_ff, hit_in;
   logic [SPECIES_W-1:0] main_species_ff, main_species_in;
   logic                 main_valid_ff, main_valid_in;

   logic [USED_W-1:0]    idx_inc;
   logic [USED_W-1:0]    pos_dec;
   logic                 start_sort;

   logic [31:0]          alu_a;
   logic [31:0]          alu_b;
   logic                 alu_eq;
   logic                 alu_lt;
   logic [31:0]          alu_sum;

   rct_alu u_alu (
      .op_a    (alu_a),
      .op_b    (alu_b),
      .addend  (item_ff.amount),
      .eq      (alu_eq),
      .lt      (alu_lt),
      .sum_sat (alu_sum)
   );

   assign idx_inc = idx_ff + USED_W'(1);
   assign pos_dec = pos_ff - USED_W'(1);

   assign req_bus.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in        = state_ff;
      item_in         = item_ff;
      hold_in         = hold_ff;
      idx_in          = idx_ff;
      pos_in          = pos_ff;
      used_in         = used_ff;
      full_seen_in    = full_seen_ff;
      hit_in          = hit_ff;
      main_species_in = main_species_ff;
      main_valid_in   = main_valid_ff;
      start_sort      = 1'b0;
      mem_wr_en       = 1'b0;
      mem_wr_addr     = pos_ff[ADDR_W-1:0];
      mem_wr_data     = hold_ff;
      mem_rd_en       = 1'b0;
      mem_rd_addr     = idx_ff[ADDR_W-1:0];
      alu_a           = mem_rd_data.species;
      alu_b           = item_ff.species;
      res_valid       = 1'b0;
      res_data        = '{main_species: main_species_ff, main_valid: main_valid_ff,
                          table_full: full_seen_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               item_in = '{kind: req_bus.kind, species: req_bus.species,
                           amount: req_bus.amount, eligible: req_bus.eligible,
                           last: req_bus.last};
               idx_in  = '0;
               hit_in  = 1'b0;
               if (req_bus.species == INVALID_SPECIES) begin
                  start_sort = req_bus.last;
               end else if (used_ff == USED_W'(0)) begin
                  state_in = ST_APPLY;
               end else begin
                  state_in = ST_FIND_RD;
               end
            end
         end
         ST_FIND_RD: begin
            mem_rd_en = 1'b1;
            state_in  = ST_FIND_CMP;
         end
         ST_FIND_CMP: begin
            alu_a = mem_rd_data.species;
            alu_b = item_ff.species;
            if (alu_eq) begin
               hit_in   = 1'b1;
               hold_in  = mem_rd_data;
               pos_in   = idx_ff;
               state_in = ST_APPLY;
            end else if (idx_inc == used_ff) begin
               state_in = ST_APPLY;
            end else begin
               idx_in   = idx_inc;
               state_in = ST_FIND_RD;
            end
         end
         ST_APPLY: begin
            alu_a = hold_ff.count;
            if (hit_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = pos_ff[ADDR_W-1:0];
               if (item_ff.kind == KIND_ELIG) begin
                  mem_wr_data = '{species: hold_ff.species, count: hold_ff.count,
                                  eligible: item_ff.eligible};
               end else begin
                  mem_wr_data = '{species: hold_ff.species, count: alu_sum,
                                  eligible: hold_ff.eligible};
               end
            end else if (item_ff.kind == KIND_ADD) begin
               if (used_ff < USED_W'(DEPTH)) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = used_ff[ADDR_W-1:0];
                  mem_wr_data = '{species: item_ff.species,
                                  count: COUNT_W'(item_ff.amount),
                                  eligible: item_ff.eligible};
                  used_in     = used_ff + USED_W'(1);
               end else begin
                  full_seen_in = 1'b1;
               end
            end
            state_in   = ST_IDLE;
            start_sort = item_ff.last;
         end
         ST_SORT_RDI: begin
            mem_rd_en = 1'b1;
            state_in  = ST_SORT_LDI;
         end
         ST_SORT_LDI: begin
            hold_in  = mem_rd_data;
            pos_in   = idx_ff;
            state_in = ST_SORT_RDJ;
         end
         ST_SORT_RDJ: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = pos_dec[ADDR_W-1:0];
            state_in    = ST_SORT_CMP;
         end
         ST_SORT_CMP: begin
            alu_a = mem_rd_data.count;
            alu_b = hold_ff.count;
            if (alu_lt) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = pos_ff[ADDR_W-1:0];
               mem_wr_data = mem_rd_data;
               pos_in      = pos_dec;
               state_in    = (pos_dec == USED_W'(0)) ? ST_SORT_PUT : ST_SORT_RDJ;
            end else begin
               state_in = ST_SORT_PUT;
            end
         end
         ST_SORT_PUT: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = pos_ff[ADDR_W-1:0];
            mem_wr_data = hold_ff;
            if (idx_inc == used_ff) begin
               idx_in   = '0;
               state_in = ST_SCAN_RD;
            end else begin
               idx_in   = idx_inc;
               state_in = ST_SORT_RDI;
            end
         end
         ST_SCAN_RD: begin
            mem_rd_en = 1'b1;
            state_in  = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            if (mem_rd_data.eligible) begin
               main_species_in = mem_rd_data.species;
               main_valid_in   = 1'b1;
               state_in        = ST_REPORT;
            end else if (idx_inc == used_ff) begin
               main_species_in = INVALID_SPECIES;
               main_valid_in   = 1'b0;
               state_in        = ST_REPORT;
            end else begin
               idx_in   = idx_inc;
               state_in = ST_SCAN_RD;
            end
         end
         ST_REPORT: begin
            res_valid = out_free;
            if (out_free) begin
               full_seen_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (start_sort) begin
         if (used_in == USED_W'(0)) begin
            main_species_in = INVALID_SPECIES;
            main_valid_in   = 1'b0;
            state_in        = ST_REPORT;
         end else if (used_in == USED_W'(1)) begin
            idx_in   = '0;
            state_in = ST_SCAN_RD;
         end else begin
            idx_in   = USED_W'(1);
            state_in = ST_SORT_RDI;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         full_seen_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         full_seen_ff <= full_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff         <= item_in;
      hold_ff         <= hold_in;
      idx_ff          <= idx_in;
      pos_ff          <= pos_in;
      hit_ff          <= hit_in;
      main_species_ff <= main_species_in;
      main_valid_ff   <= main_valid_in;
   end

endmodule

[hdl/ranked_contributor_table_top.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ranked_contributor_table_top: ranked contributor table
// Accumulates per-identifier counts and reports the top eligible entry.
// -----------------------------------------------------------------------------
// Request beats carry one contribution or eligibility item; the beat with
// last set closes a batch and yields exactly one response beat with the
// first eligible identifier after a stable sort by decreasing count, plus
// the table-full flag of that batch. Other request beats yield nothing.
// One item is in flight at a time; req ready is high only while idle.
// The entry search reads the table memory one entry at a time, with a read
// state and a compare state per entry, until a match or the last entry.
// A batch end adds the insertion sort on the same single read port: it
// reads each entry, shifts smaller-count entries toward the back and then
// places the held entry; then comes the eligibility scan over the sorted
// entries, and then the result is handed to the response register.
// Reset empties the table at once (no clearing pass) and drops any
// pending response. A stalled response holds in its output register; the
// next item is still accepted, and only a following batch end waits for
// the register to drain.
// -----------------------------------------------------------------------------
module ranked_contributor_table_top #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   rct_req_if.sink   req_bus,
   rct_rsp_if.source rsp_bus
);
   import rct_pkg::*;

   localparam int ADDR_W = $clog2(TABLE_DEPTH);

   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;
   entry_type         mem_wr_data;
   logic              mem_rd_en;
   logic [ADDR_W-1:0] mem_rd_addr;
   entry_type         mem_rd_data;

   result_type        res_data;
   logic              res_valid;
   logic              out_free;

   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_data_ff, rsp_data_in;

   rct_mem #(.DEPTH(TABLE_DEPTH)) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   rct_ctrl #(.DEPTH(TABLE_DEPTH)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .res_data    (res_data),
      .res_valid   (res_valid),
      .out_free    (out_free)
   );

   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.main_species = rsp_data_ff.main_species;
   assign rsp_bus.main_valid   = rsp_data_ff.main_valid;
   assign rsp_bus.table_full   = rsp_data_ff.table_full;

endmodule

[hdl/rct_checker.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rct_checker: port-level checks of the ranked contributor table
// Busy after a request beat, response coding, no response after reset and response hold under stall.
// -----------------------------------------------------------------------------
module rct_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [31:0] req_species,
   input logic        req_last,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_main_species,
   input logic        rsp_main_valid
);
   import rct_pkg::*;

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_last || req_species != INVALID_SPECIES)
      |=> !req_ready)
      else $error("request accepted on consecutive cycles");

   a_none_is_invalid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_main_valid |-> rsp_main_species == INVALID_SPECIES)
      else $error("no main entry but identifier is not the invalid value");

   a_main_not_invalid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_main_valid |-> rsp_main_species != INVALID_SPECIES)
      else $error("main entry reported with the invalid identifier");

   a_rsp_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_main_species)
                                  && $stable(rsp_main_valid))
      else $error("stalled response beat changed");

endmodule

bind ranked_contributor_table_top rct_checker u_rct_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .req_species      (req_bus.species),
   .req_last         (req_bus.last),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_main_species (rsp_bus.main_species),
   .rsp_main_valid   (rsp_bus.main_valid)
);
